// ----- src/rpsm_pkg.sv -----
// ----------------------------------------------------------------------------
// rpsm_pkg: shared types and constants of the reference picture slot manager
// Request and result payloads, decoded commands, action codes and defaults.
// ----------------------------------------------------------------------------
package rpsm_pkg;

  localparam int POOL_SLOTS_DEF = 32;
  localparam int LIST_DEPTH_DEF = 16;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [2:0] ACT_ACQUIRE = 3'd0;
  localparam logic [2:0] ACT_ADD     = 3'd1;
  localparam logic [2:0] ACT_REMOVE  = 3'd2;
  localparam logic [2:0] ACT_CLEAR   = 3'd3;
  localparam logic [2:0] ACT_LIST    = 3'd4;

  localparam logic REG_POOL_INITIAL = 1'b0;
  localparam logic REG_GROW_ENABLED = 1'b1;

  localparam logic [5:0] POOL_INITIAL_RST = 6'd16;
  localparam logic       GROW_ENABLED_RST = 1'b0;

  typedef struct packed {
    logic [2:0] action;
    logic [4:0] slot;
  } in_item_t;

  typedef struct packed {
    logic       ok;
    logic [4:0] slot_out;
    logic [3:0] ref_position;
    logic       last;
    logic [4:0] list_count;
    logic [5:0] pool_count;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_ACQUIRE,
    OP_ADD,
    OP_REMOVE,
    OP_CLEAR,
    OP_LIST,
    OP_INVALID
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] slot;
  } cmd_t;

endpackage

// ----- src/reference_picture_slot_manager.sv -----
// ----------------------------------------------------------------------------
// reference_picture_slot_manager: picture slot and reference list manager
// Path: a taken request passes the intake register and the command queue to
// the execution stage, which drives the result register.
// Throughput: one request per cycle while nothing stalls; list and clear hold
// the execution stage, walking the reference ring one entry per unstalled cycle.
// Reset: synchronous; every slot free, list empty, registers at their defaults.
// ----------------------------------------------------------------------------
module reference_picture_slot_manager
  import rpsm_pkg::*;
#(
  parameter int POOL_SLOTS = POOL_SLOTS_DEF,
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [5:0] pool_initial_r;
  logic [5:0] pool_initial_nxt;
  logic       grow_enabled_r;
  logic       grow_enabled_nxt;
  logic       cfg_write;
  logic       push;
  cmd_t       push_cmd;
  logic       q_full;
  logic       q_valid;
  cmd_t       q_cmd;
  logic       pop;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    pool_initial_nxt = pool_initial_r;
    grow_enabled_nxt = grow_enabled_r;
    if (cfg_write) begin
      case (paddr[2])
        REG_POOL_INITIAL: pool_initial_nxt = pwdata[5:0];
        REG_GROW_ENABLED: grow_enabled_nxt = pwdata[0];
        default: begin
          pool_initial_nxt = pool_initial_r;
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_POOL_INITIAL: prdata = {26'd0, pool_initial_r};
      REG_GROW_ENABLED: prdata = {31'd0, grow_enabled_r};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_initial_r <= POOL_INITIAL_RST;
      grow_enabled_r <= GROW_ENABLED_RST;
    end else begin
      pool_initial_r <= pool_initial_nxt;
      grow_enabled_r <= grow_enabled_nxt;
    end
  end

  rpsm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  rpsm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  rpsm_back #(
    .POOL_SLOTS (POOL_SLOTS),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .pop          (pop),
    .pool_initial (pool_initial_r),
    .grow_enabled (grow_enabled_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule

// ----- src/rpsm_front.sv -----
// ----------------------------------------------------------------------------
// rpsm_front: request intake
// Accepts requests, decodes the action into a command and hands it to the queue.
// ----------------------------------------------------------------------------
module rpsm_front
  import rpsm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     push,
  output cmd_t     push_cmd,
  input  logic     q_full
);

  logic cmd_valid_r;
  logic cmd_valid_nxt;
  cmd_t cmd_r;
  cmd_t cmd_nxt;
  logic accept;

  assign push     = cmd_valid_r && !q_full;
  assign in_stall = cmd_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign push_cmd = cmd_r;

  always_comb begin
    cmd_nxt.slot = in_data.slot;
    case (in_data.action)
      ACT_ACQUIRE: cmd_nxt.op = OP_ACQUIRE;
      ACT_ADD:     cmd_nxt.op = OP_ADD;
      ACT_REMOVE:  cmd_nxt.op = OP_REMOVE;
      ACT_CLEAR:   cmd_nxt.op = OP_CLEAR;
      ACT_LIST:    cmd_nxt.op = OP_LIST;
      default:     cmd_nxt.op = OP_INVALID;
    endcase
  end

  always_comb begin
    cmd_valid_nxt = cmd_valid_r;
    if (accept) begin
      cmd_valid_nxt = 1'b1;
    end else if (push) begin
      cmd_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
    end
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

// ----- src/rpsm_queue.sv -----
// ----------------------------------------------------------------------------
// rpsm_queue: command queue
// Short FIFO that decouples command intake from command execution.
// ----------------------------------------------------------------------------
module rpsm_queue
  import rpsm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic q_full,
  input  logic pop,
  output logic q_valid,
  output cmd_t q_cmd
);

  localparam int PTRW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            entry_r [QUEUE_DEPTH];
  logic [PTRW-1:0] wr_ptr_r;
  logic [PTRW-1:0] wr_ptr_nxt;
  logic [PTRW-1:0] rd_ptr_r;
  logic [PTRW-1:0] rd_ptr_nxt;
  logic [CNTW-1:0] fill_r;
  logic [CNTW-1:0] fill_nxt;

  assign q_full  = (fill_r == CNTW'(QUEUE_DEPTH));
  assign q_valid = (fill_r != '0);
  assign q_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTRW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTRW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTRW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTRW'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + CNTW'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- src/rpsm_back.sv -----
// ----------------------------------------------------------------------------
// rpsm_back: command execution
// Holds the free marks and the reference ring, executes commands and drives
// the result register; list and clear step one ring entry per unstalled cycle.
// ----------------------------------------------------------------------------
module rpsm_back
  import rpsm_pkg::*;
#(
  parameter int POOL_SLOTS = POOL_SLOTS_DEF,
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  cmd_t      q_cmd,
  output logic      pop,
  input  logic [5:0] pool_initial,
  input  logic      grow_enabled,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int SW   = $clog2(POOL_SLOTS);
  localparam int PW   = $clog2(POOL_SLOTS + 1);
  localparam int SUMW = ((PW > 6) ? PW : 6) + 1;
  localparam int CMPW = (PW > 5) ? PW : 5;
  localparam int LW   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNW  = $clog2(LIST_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LIST,
    S_CLEAR
  } state_t;

  state_t                state_r;
  state_t                state_nxt;
  logic [POOL_SLOTS-1:0] slot_free_r;
  logic [POOL_SLOTS-1:0] slot_free_nxt;
  logic [PW-1:0]         extra_r;
  logic [PW-1:0]         extra_nxt;
  logic [4:0]            list_r [LIST_DEPTH];
  logic [LW-1:0]         head_r;
  logic [LW-1:0]         head_nxt;
  logic [CNW-1:0]        count_r;
  logic [CNW-1:0]        count_nxt;
  logic [LW-1:0]         walk_r;
  logic [LW-1:0]         walk_nxt;
  logic [CNW-1:0]        pos_r;
  logic [CNW-1:0]        pos_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  out_item_t             out_data_r;
  out_item_t             out_data_nxt;

  logic [SUMW-1:0]       pool_sum;
  logic [PW-1:0]         pool_size;
  logic [POOL_SLOTS-1:0] avail;
  logic [POOL_SLOTS-1:0] lowest;
  logic [SW-1:0]         pick_idx;
  logic                  any_free;
  logic                  can_grow;
  logic [LW-1:0]         tail_idx;
  logic [LW-1:0]         rd_idx;
  logic [4:0]            rd_slot;
  logic [POOL_SLOTS-1:0] release_vec;
  logic                  out_can;
  logic                  walk_last;
  logic                  list_we;
  logic [LW-1:0]         list_wa;

  function automatic logic [LW-1:0] wrap_add(input logic [LW-1:0] a, input logic [LW:0] b);
    logic [LW:0] s;
    s = {1'b0, a} + b;
    if (s >= (LW + 1)'(LIST_DEPTH)) begin
      s = s - (LW + 1)'(LIST_DEPTH);
    end
    return s[LW-1:0];
  endfunction

  assign pool_sum  = SUMW'(pool_initial) + SUMW'(extra_r);
  assign pool_size = (pool_sum > SUMW'(POOL_SLOTS)) ? PW'(POOL_SLOTS) : PW'(pool_sum);
  assign can_grow  = grow_enabled && (pool_size < PW'(POOL_SLOTS));
  assign out_can   = !out_valid_r || !out_stall;
  assign tail_idx  = wrap_add(head_r, (LW + 1)'(count_r - CNW'(1)));
  assign rd_idx    = (state_r == S_IDLE) ? tail_idx : walk_r;
  assign rd_slot   = list_r[rd_idx];
  assign walk_last = ((pos_r + CNW'(1)) == count_r);

  always_comb begin
    for (int i = 0; i < POOL_SLOTS; i++) begin
      avail[i] = slot_free_r[i] && (PW'(i) < pool_size);
    end
    any_free = |avail;
    lowest   = avail & (~avail + POOL_SLOTS'(1));
    pick_idx = '0;
    for (int i = 0; i < POOL_SLOTS; i++) begin
      if (lowest[i]) begin
        pick_idx = pick_idx | SW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < POOL_SLOTS; i++) begin
      release_vec[i] = (CMPW'(rd_slot) == CMPW'(i)) && (CMPW'(rd_slot) < CMPW'(pool_size));
    end
  end

  always_comb begin
    state_nxt     = state_r;
    slot_free_nxt = slot_free_r;
    extra_nxt     = extra_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    walk_nxt      = walk_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    list_we       = 1'b0;
    list_wa       = head_r;

    out_data_nxt.ok           = 1'b0;
    out_data_nxt.slot_out     = '0;
    out_data_nxt.ref_position = '0;
    out_data_nxt.last         = 1'b1;
    out_data_nxt.pool_count   = 6'(pool_size);

    case (state_r)
      S_IDLE: begin
        if (out_can && q_valid) begin
          pop           = 1'b1;
          out_valid_nxt = 1'b1;
          case (q_cmd.op)
            OP_ACQUIRE: begin
              if (any_free) begin
                slot_free_nxt[pick_idx] = 1'b0;
                out_data_nxt.ok         = 1'b1;
                out_data_nxt.slot_out   = 5'(pick_idx);
              end else if (can_grow) begin
                slot_free_nxt[SW'(pool_size)] = 1'b0;
                extra_nxt                     = extra_r + PW'(1);
                out_data_nxt.ok               = 1'b1;
                out_data_nxt.slot_out         = 5'(pool_size);
                out_data_nxt.pool_count       = 6'(pool_size + PW'(1));
              end
            end
            OP_ADD: begin
              if (count_r != CNW'(LIST_DEPTH)) begin
                head_nxt        = (head_r == '0) ? LW'(LIST_DEPTH - 1) : head_r - LW'(1);
                list_we         = 1'b1;
                list_wa         = head_nxt;
                count_nxt       = count_r + CNW'(1);
                out_data_nxt.ok = 1'b1;
              end
            end
            OP_REMOVE: begin
              if (count_r != '0) begin
                count_nxt       = count_r - CNW'(1);
                slot_free_nxt   = slot_free_r | release_vec;
                out_data_nxt.ok = 1'b1;
              end
            end
            OP_CLEAR: begin
              if (count_r == '0) begin
                out_data_nxt.ok = 1'b1;
              end else begin
                out_valid_nxt = out_valid_r && out_stall;
                walk_nxt      = head_r;
                pos_nxt       = '0;
                state_nxt     = S_CLEAR;
              end
            end
            OP_LIST: begin
              if (count_r == '0) begin
                out_data_nxt.ok = 1'b1;
              end else begin
                out_valid_nxt = out_valid_r && out_stall;
                walk_nxt      = head_r;
                pos_nxt       = '0;
                state_nxt     = S_LIST;
              end
            end
            default: begin
              out_data_nxt.ok = 1'b0;
            end
          endcase
        end
      end
      S_LIST: begin
        if (out_can) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.ok           = 1'b1;
          out_data_nxt.slot_out     = rd_slot;
          out_data_nxt.ref_position = 4'(pos_r);
          out_data_nxt.last         = walk_last;
          walk_nxt = (walk_r == LW'(LIST_DEPTH - 1)) ? '0 : walk_r + LW'(1);
          pos_nxt  = pos_r + CNW'(1);
          if (walk_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_CLEAR: begin
        if (!walk_last) begin
          slot_free_nxt = slot_free_r | release_vec;
          walk_nxt = (walk_r == LW'(LIST_DEPTH - 1)) ? '0 : walk_r + LW'(1);
          pos_nxt  = pos_r + CNW'(1);
        end else if (out_can) begin
          slot_free_nxt   = slot_free_r | release_vec;
          count_nxt       = '0;
          out_valid_nxt   = 1'b1;
          out_data_nxt.ok = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_data_nxt.list_count = 5'(count_nxt);
    if (!(out_valid_nxt && !(out_valid_r && out_stall))) begin
      out_data_nxt = out_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_free_r <= '1;
      extra_r     <= '0;
      head_r      <= '0;
      count_r     <= '0;
      walk_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_free_r <= slot_free_nxt;
      extra_r     <= extra_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      walk_r      <= walk_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    if (list_we) begin
      list_r[list_wa] <= q_cmd.slot;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- tb/tb_reference_picture_slot_manager.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_reference_picture_slot_manager: self-checking bench for the slot manager
// A directed sequence, list-full and pool-growth tests, and random request
// streams run under several pool settings. A behavioral model of the slot
// pool and reference list predicts every result, and a monitor compares them.
// Both sides idle at random, and one long output stall fills the pipeline.
// ----------------------------------------------------------------------------
module tb_reference_picture_slot_manager;
  import rpsm_pkg::*;

  localparam logic [2:0] ACT_RESERVED_LO = 3'd5;
  localparam logic [2:0] ACT_RESERVED_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bit          free_mark [POOL_SLOTS_DEF];
  logic [4:0]  ref_slots [LIST_DEPTH_DEF];
  logic [4:0]  ref_depth;
  logic [5:0]  extra_count;
  logic [5:0]  cfg_pool_initial;
  logic        cfg_grow;

  out_item_t   expected_results [$];
  int          mismatch_count;
  int          rx_hold;
  int          rx_wait;
  bit          idle_on;

  reference_picture_slot_manager u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  function automatic int pool_now();
    int n;
    n = cfg_pool_initial + extra_count;
    return (n > POOL_SLOTS_DEF) ? POOL_SLOTS_DEF : n;
  endfunction

  function automatic out_item_t make_result(input logic ok, input logic [4:0] s,
                                            input logic [3:0] pos, input logic last);
    out_item_t r;
    int pool;
    pool = pool_now();
    r.ok = ok;
    r.slot_out = s;
    r.ref_position = pos;
    r.last = last;
    r.list_count = ref_depth;
    r.pool_count = pool[5:0];
    return r;
  endfunction

  function automatic void expect_result(input out_item_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void release_slot(input logic [4:0] s);
    if (s < pool_now()) begin
      free_mark[s] = 1'b1;
    end
  endfunction

  task automatic predict_request(input in_item_t req);
    int n;
    bit found;
    found = 1'b0;
    case (req.action)
      ACT_ACQUIRE: begin
        n = pool_now();
        for (int i = 0; i < n; i++) begin
          if (!found && free_mark[i]) begin
            free_mark[i] = 1'b0;
            found = 1'b1;
            expect_result(make_result(1'b1, i[4:0], 4'd0, 1'b1));
          end
        end
        if (!found && cfg_grow && n < POOL_SLOTS_DEF) begin
          free_mark[n] = 1'b0;
          extra_count++;
          expect_result(make_result(1'b1, n[4:0], 4'd0, 1'b1));
        end else if (!found) begin
          expect_result(make_result(1'b0, 5'd0, 4'd0, 1'b1));
        end
      end
      ACT_ADD: begin
        if (ref_depth >= LIST_DEPTH_DEF) begin
          expect_result(make_result(1'b0, 5'd0, 4'd0, 1'b1));
        end else begin
          for (int i = ref_depth; i > 0; i--) begin
            ref_slots[i] = ref_slots[i - 1];
          end
          ref_slots[0] = req.slot;
          ref_depth++;
          expect_result(make_result(1'b1, 5'd0, 4'd0, 1'b1));
        end
      end
      ACT_REMOVE: begin
        if (ref_depth == 0) begin
          expect_result(make_result(1'b0, 5'd0, 4'd0, 1'b1));
        end else begin
          ref_depth--;
          release_slot(ref_slots[ref_depth]);
          expect_result(make_result(1'b1, 5'd0, 4'd0, 1'b1));
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < ref_depth; i++) begin
          release_slot(ref_slots[i]);
        end
        ref_depth = '0;
        expect_result(make_result(1'b1, 5'd0, 4'd0, 1'b1));
      end
      ACT_LIST: begin
        if (ref_depth == 0) begin
          expect_result(make_result(1'b1, 5'd0, 4'd0, 1'b1));
        end else begin
          for (int i = 0; i < ref_depth; i++) begin
            expect_result(make_result(1'b1, ref_slots[i], i[3:0],
                                      (i + 1 == ref_depth)));
          end
        end
      end
      default: begin
        expect_result(make_result(1'b0, 5'd0, 4'd0, 1'b1));
      end
    endcase
  endtask

  function automatic void check_field(input string name, input logic [5:0] want,
                                      input logic [5:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, got %p", $time, out_data);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("ok", 6'(want.ok), 6'(out_data.ok));
        check_field("slot_out", 6'(want.slot_out), 6'(out_data.slot_out));
        check_field("ref_position", 6'(want.ref_position), 6'(out_data.ref_position));
        check_field("last", 6'(want.last), 6'(out_data.last));
        check_field("list_count", 6'(want.list_count), 6'(out_data.list_count));
        check_field("pool_count", want.pool_count, out_data.pool_count);
      end
      rx_wait = idle_on ? $urandom_range(3, 0) : 0;
    end
  end

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold--;
    end else if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_request(input logic [2:0] act, input logic [4:0] slot_index);
    in_item_t req;
    int gap;
    req.action = act;
    req.slot = slot_index;
    gap = idle_on ? $urandom_range(3, 0) : 0;
    @(negedge clk);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(req);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LIST_DEPTH_DEF + 8) @(posedge clk);
  endtask

  task automatic write_register(input logic reg_index, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_index, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (reg_index == REG_POOL_INITIAL) begin
      cfg_pool_initial = value[5:0];
    end else begin
      cfg_grow = value[0];
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(input int pool_initial, input bit grow);
    wait_for_drain();
    write_register(REG_POOL_INITIAL, pool_initial);
    write_register(REG_GROW_ENABLED, 32'(grow));
  endtask

  task automatic run_random(input int count);
    logic [2:0] act;
    logic [4:0] s;
    int r;
    int pool;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99, 0);
      if (r < 25) begin
        act = ACT_ACQUIRE;
      end else if (r < 55) begin
        act = ACT_ADD;
      end else if (r < 70) begin
        act = ACT_REMOVE;
      end else if (r < 75) begin
        act = ACT_CLEAR;
      end else if (r < 93) begin
        act = ACT_LIST;
      end else begin
        act = 3'($urandom_range(ACT_RESERVED_HI, ACT_RESERVED_LO));
      end
      pool = pool_now();
      if (pool > 0 && $urandom_range(1, 0) == 1) begin
        s = 5'($urandom_range(pool - 1, 0));
      end else begin
        s = 5'($urandom);
      end
      send_request(act, s);
    end
  endtask

  task automatic test_directed();
    send_request(ACT_LIST, 5'd0);
    send_request(ACT_REMOVE, 5'd31);
    send_request(ACT_CLEAR, 5'd0);
    send_request(ACT_RESERVED_LO, 5'd31);
    send_request(ACT_RESERVED_HI, 5'd0);
    send_request(ACT_ACQUIRE, 5'd0);
    send_request(ACT_ACQUIRE, 5'd31);
    send_request(ACT_ADD, 5'd31);
    send_request(ACT_ADD, 5'd0);
    send_request(ACT_ADD, 5'd1);
    send_request(ACT_LIST, 5'd0);
    send_request(ACT_REMOVE, 5'd0);
    send_request(ACT_ACQUIRE, 5'd0);
    send_request(ACT_CLEAR, 5'd0);
    send_request(ACT_ACQUIRE, 5'd0);
    send_request(ACT_LIST, 5'd0);
  endtask

  task automatic test_list_full();
    send_request(ACT_ADD, 5'd31);
    repeat (LIST_DEPTH_DEF) send_request(ACT_ADD, 5'($urandom));
    send_request(ACT_LIST, 5'd0);
    send_request(ACT_REMOVE, 5'd0);
    send_request(ACT_CLEAR, 5'd0);
  endtask

  task automatic test_pool_sizes();
    configure(0, 1'b0);
    run_random(50);
    idle_on = 1'b0;
    configure(32, 1'b0);
    run_random(60);
    idle_on = 1'b1;
    configure($urandom_range(31, 1), 1'b0);
    run_random(60);
    configure(16, 1'b0);
    run_random(60);
  endtask

  task automatic test_backpressure();
    configure(8, 1'b0);
    send_request(ACT_ADD, 5'd3);
    rx_hold = 80;
    run_random(40);
    wait_for_drain();
    run_random(10);
  endtask

  task automatic test_growth();
    configure(3, 1'b1);
    repeat (35) send_request(ACT_ACQUIRE, 5'($urandom));
    send_request(ACT_CLEAR, 5'd0);
    send_request(ACT_LIST, 5'd0);
  endtask

  task automatic test_random_growth();
    configure($urandom_range(32, 0), 1'b1);
    run_random(60);
    configure(32, 1'b1);
    run_random(60);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_on = 1'b1;
    rx_hold = 0;
    rx_wait = 0;
    mismatch_count = 0;
    for (int i = 0; i < POOL_SLOTS_DEF; i++) begin
      free_mark[i] = 1'b1;
    end
    ref_depth = '0;
    extra_count = '0;
    cfg_pool_initial = POOL_INITIAL_RST;
    cfg_grow = GROW_ENABLED_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_list_full();
    test_pool_sizes();
    test_backpressure();
    test_growth();
    test_random_growth();
    wait_for_drain();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
src/rpsm_pkg.sv
src/rpsm_front.sv
src/rpsm_queue.sv
src/rpsm_back.sv
src/reference_picture_slot_manager.sv
tb/tb_reference_picture_slot_manager.sv
